[rtl/gcpm_pkg.sv]
// Shared types, widths and codes for the greedy cone pairing block.
`timescale 1ns / 1ps

package gcpm_pkg;

  localparam int COORD_W        = 16;
  localparam int GATE_W         = 15;
  localparam int GATE_SQ_W      = 2 * GATE_W;
  localparam int DIST_W         = 2 * COORD_W + 1;
  localparam int SLOT_W         = 6;
  localparam int STAT_W         = 3;
  localparam int REQ_W          = 2;
  localparam int MAX_CONES_DEF  = 64;

  localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(1587);

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PAIR  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;

  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd0;
  localparam logic [STAT_W-1:0] ST_STORED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_PAIRED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOPART  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [COORD_W-1:0] mid_x;
    logic signed [COORD_W-1:0] mid_y;
    logic [SLOT_W-1:0]         partner_slot;
  } out_res_t;

  typedef struct packed {
    logic                      used;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic                      found;
    logic                      pipe_busy;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         dist_sq;
  } best_t;

endpackage

[rtl/gcpm_cone_mem.sv]
// Cone table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module gcpm_cone_mem #(
  parameter int DEPTH = gcpm_pkg::MAX_CONES_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  gcpm_pkg::entry_t     wdata,
  input  logic                 re,
  input  logic [IDX_W-1:0]     raddr,
  output gcpm_pkg::entry_t     rdata
);
  import gcpm_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/gcpm_dist_unit.sv]
// Pipelined squared-distance unit that keeps the nearest unused cone of a scan.
`timescale 1ns / 1ps

module gcpm_dist_unit #(
  parameter int IDX_W = $clog2(gcpm_pkg::MAX_CONES_DEF)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          scan_clear,
  input  logic                          issue_valid,
  input  logic [IDX_W-1:0]              issue_idx,
  input  gcpm_pkg::entry_t              rdata,
  input  logic signed [gcpm_pkg::COORD_W-1:0] px,
  input  logic signed [gcpm_pkg::COORD_W-1:0] py,
  output gcpm_pkg::best_t               best,
  output logic [IDX_W-1:0]              best_idx
);
  import gcpm_pkg::*;

  logic                      v_a_r;
  logic [IDX_W-1:0]          idx_a_r;

  logic                      v_b_r;
  logic [IDX_W-1:0]          idx_b_r;
  logic [COORD_W-1:0]        adx_b_r;
  logic [COORD_W-1:0]        ady_b_r;
  logic signed [COORD_W-1:0] x_b_r;
  logic signed [COORD_W-1:0] y_b_r;

  logic                      v_c_r;
  logic [IDX_W-1:0]          idx_c_r;
  logic [2*COORD_W-1:0]      sqx_c_r;
  logic [2*COORD_W-1:0]      sqy_c_r;
  logic signed [COORD_W-1:0] x_c_r;
  logic signed [COORD_W-1:0] y_c_r;

  logic                      found_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic signed [COORD_W-1:0] best_x_r;
  logic signed [COORD_W-1:0] best_y_r;
  logic [DIST_W-1:0]         best_dist_r;

  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic [COORD_W:0]          dx_mag;
  logic [COORD_W:0]          dy_mag;
  logic [DIST_W-1:0]         dist_sum;
  logic                      take;

  always_comb begin
    dx = {rdata.x[COORD_W-1], rdata.x} - {px[COORD_W-1], px};
    dy = {rdata.y[COORD_W-1], rdata.y} - {py[COORD_W-1], py};
    dx_mag = dx[COORD_W] ? (~dx + 1'b1) : dx;
    dy_mag = dy[COORD_W] ? (~dy + 1'b1) : dy;
    dist_sum = {1'b0, sqx_c_r} + {1'b0, sqy_c_r};
    take = v_c_r && (!found_r || (dist_sum < best_dist_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      v_a_r <= issue_valid;
      v_b_r <= v_a_r && !rdata.used;
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    idx_a_r <= issue_idx;
    idx_b_r <= idx_a_r;
    adx_b_r <= dx_mag[COORD_W-1:0];
    ady_b_r <= dy_mag[COORD_W-1:0];
    x_b_r   <= rdata.x;
    y_b_r   <= rdata.y;
    idx_c_r <= idx_b_r;
    sqx_c_r <= adx_b_r * adx_b_r;
    sqy_c_r <= ady_b_r * ady_b_r;
    x_c_r   <= x_b_r;
    y_c_r   <= y_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (scan_clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r  <= idx_c_r;
      best_x_r    <= x_c_r;
      best_y_r    <= y_c_r;
      best_dist_r <= dist_sum;
    end
  end

  always_comb begin
    best.found     = found_r;
    best.pipe_busy = v_a_r || v_b_r || v_c_r;
    best.x         = best_x_r;
    best.y         = best_y_r;
    best.dist_sq   = best_dist_r;
  end

  assign best_idx = best_idx_r;

endmodule

[rtl/greedy_cone_pair_midpoints_unit.sv]
// Top level of the greedy cone pairing block with its request sequencer.
//
//  Channel  Ports                        Handshake
//  -------  ---------------------------  -----------------------------------
//  request  start, busy, in_req          taken when start is high, busy low
//  result   out_valid, out_res           one-cycle strobe, always taken
//  config   cfg_we, cfg_wdata            written when cfg_we is high
//
// Clear, load and reserved requests answer in the next cycle and never raise busy,
// and so does a pair request on an empty table.
// Any other pair request holds busy while the table is read one slot per cycle over the
// N stored cones and then while the distance pipeline drains, which is shorter when the
// last slots read are already used.
// The result strobe comes in the same cycle as busy falls.
// Reset is synchronous and empties the table and restores the gate distance.
// The receiver cannot stall the result channel.
`timescale 1ns / 1ps

module greedy_cone_pair_midpoints_unit #(
  parameter int MAX_CONES = gcpm_pkg::MAX_CONES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  gcpm_pkg::in_req_t             in_req,
  output logic                          out_valid,
  output gcpm_pkg::out_res_t            out_res,
  input  logic                          cfg_we,
  input  logic [gcpm_pkg::GATE_W-1:0]   cfg_wdata
);
  import gcpm_pkg::*;

  localparam int IDX_W = $clog2(MAX_CONES);
  localparam int CNT_W = $clog2(MAX_CONES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          scan_idx_r, scan_idx_nxt;
  logic signed [COORD_W-1:0] pos_x_r, pos_x_nxt;
  logic signed [COORD_W-1:0] pos_y_r, pos_y_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_res_t                  out_res_r, out_res_nxt;
  logic [GATE_W-1:0]         gate_r;
  logic [GATE_SQ_W-1:0]      gate_sq_r;

  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  entry_t                    mem_wdata;
  logic                      mem_re;
  entry_t                    mem_rdata;
  logic                      scan_clear;
  best_t                     best;
  logic [IDX_W-1:0]          best_idx;
  logic signed [COORD_W:0]   sum_x;
  logic signed [COORD_W:0]   sum_y;

  gcpm_cone_mem #(
    .DEPTH (MAX_CONES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_idx_r),
    .rdata (mem_rdata)
  );

  gcpm_dist_unit #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .scan_clear  (scan_clear),
    .issue_valid (mem_re),
    .issue_idx   (scan_idx_r),
    .rdata       (mem_rdata),
    .px          (pos_x_r),
    .py          (pos_y_r),
    .best        (best),
    .best_idx    (best_idx)
  );

  always_comb begin
    sum_x = {pos_x_r[COORD_W-1], pos_x_r} + {best.x[COORD_W-1], best.x};
    sum_y = {pos_y_r[COORD_W-1], pos_y_r} + {best.y[COORD_W-1], best.y};
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    out_res_nxt.status = ST_NOPART;
    mem_we        = 1'b0;
    mem_waddr     = count_r[IDX_W-1:0];
    mem_wdata     = '0;
    mem_re        = 1'b0;
    scan_clear    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_req.req_type)
            REQ_CLEAR: begin
              count_nxt          = '0;
              out_valid_nxt      = 1'b1;
              out_res_nxt.status = ST_CLEARED;
            end
            REQ_LOAD: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_W'(MAX_CONES)) begin
                out_res_nxt.status = ST_FULL;
              end else begin
                mem_we                   = 1'b1;
                mem_wdata.used           = 1'b0;
                mem_wdata.x              = in_req.pos_x;
                mem_wdata.y              = in_req.pos_y;
                count_nxt                = count_r + CNT_W'(1);
                out_res_nxt.status       = ST_STORED;
                out_res_nxt.partner_slot = SLOT_W'(count_r[IDX_W-1:0]);
              end
            end
            REQ_PAIR: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                pos_x_nxt    = in_req.pos_x;
                pos_y_nxt    = in_req.pos_y;
                scan_idx_nxt = '0;
                scan_clear   = 1'b1;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_re = 1'b1;
        if (CNT_W'(scan_idx_r) == count_r - CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!best.pipe_busy) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (best.found && (best.dist_sq <= DIST_W'(gate_sq_r))) begin
            mem_we                   = 1'b1;
            mem_waddr                = best_idx;
            mem_wdata.used           = 1'b1;
            mem_wdata.x              = best.x;
            mem_wdata.y              = best.y;
            out_res_nxt.status       = ST_PAIRED;
            out_res_nxt.mid_x        = sum_x[COORD_W:1];
            out_res_nxt.mid_y        = sum_y[COORD_W:1];
            out_res_nxt.partner_slot = SLOT_W'(best_idx);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      gate_r      <= GATE_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        gate_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    out_res_r  <= out_res_nxt;
    gate_sq_r  <= gate_r * gate_r;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[rtl/gcpm_checker.sv]
// Port-level checker for the greedy cone pairing block and its bind.
`timescale 1ns / 1ps

module gcpm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input gcpm_pkg::in_req_t             in_req,
  input logic                          out_valid,
  input gcpm_pkg::out_res_t            out_res
);
  import gcpm_pkg::*;

  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.req_type != REQ_PAIR) |=> out_valid && !busy)
    else $error("Clear, load or reserved request did not answer in the next cycle.");

  a_pair_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.req_type == REQ_PAIR) |=> out_valid || busy)
    else $error("Pair request neither answered nor started a scan.");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("Scan finished without a result strobe.");

  a_mid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status != ST_PAIRED) |-> out_res.mid_x == '0 && out_res.mid_y == '0)
    else $error("Midpoint is not zero on an unpaired result.");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status == ST_CLEARED || out_res.status == ST_NOPART ||
                  out_res.status == ST_FULL) |-> out_res.partner_slot == '0)
    else $error("Slot is not zero on a result without a slot.");

endmodule

bind greedy_cone_pair_midpoints_unit gcpm_checker u_gcpm_checker (.*);

[sim/gcpm_result_checker.sv]
// Result checker for the greedy cone pairing block: predicts each answer and compares it.
`timescale 1ns / 1ps

module gcpm_result_checker
  import gcpm_pkg::*;
#(
  parameter int TABLE_DEPTH = MAX_CONES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_req_t           in_req,
  input  logic              out_valid,
  input  out_res_t          out_res,
  input  logic              cfg_we,
  input  logic [GATE_W-1:0] cfg_wdata,
  output int                errors,
  output int                waiting,
  output int                checked,
  output int                paired,
  output int                full_hits
);

  logic signed [COORD_W-1:0] yel_x [TABLE_DEPTH];
  logic signed [COORD_W-1:0] yel_y [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    yel_used;
  int                        yel_count;
  logic [GATE_W-1:0]         gate_q;
  out_res_t                  answers_due [$];

  task automatic answer_for(input in_req_t r, output out_res_t a);
    longint                dx, dy, d, best_d, g2;
    int                    best_i;
    logic signed [COORD_W:0] sum_x, sum_y;
    a = '0;
    a.status = ST_NOPART;
    case (r.req_type)
      REQ_CLEAR: begin
        yel_used = '0;
        yel_count = 0;
        a.status = ST_CLEARED;
      end
      REQ_LOAD: begin
        if (yel_count >= TABLE_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          yel_x[yel_count] = r.pos_x;
          yel_y[yel_count] = r.pos_y;
          yel_used[yel_count] = 1'b0;
          a.status = ST_STORED;
          a.partner_slot = SLOT_W'(yel_count);
          yel_count++;
        end
      end
      REQ_PAIR: begin
        best_i = -1;
        best_d = 0;
        for (int i = 0; i < yel_count; i++) begin
          if (!yel_used[i]) begin
            dx = longint'($signed(r.pos_x)) - longint'($signed(yel_x[i]));
            dy = longint'($signed(r.pos_y)) - longint'($signed(yel_y[i]));
            d = dx * dx + dy * dy;
            if (best_i < 0 || d < best_d) begin
              best_i = i;
              best_d = d;
            end
          end
        end
        g2 = longint'(gate_q) * longint'(gate_q);
        if (best_i >= 0 && best_d <= g2) begin
          yel_used[best_i] = 1'b1;
          sum_x = {r.pos_x[COORD_W-1], r.pos_x} + {yel_x[best_i][COORD_W-1], yel_x[best_i]};
          sum_y = {r.pos_y[COORD_W-1], r.pos_y} + {yel_y[best_i][COORD_W-1], yel_y[best_i]};
          a.status = ST_PAIRED;
          a.mid_x = sum_x[COORD_W:1];
          a.mid_y = sum_y[COORD_W:1];
          a.partner_slot = SLOT_W'(best_i);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_res_t expected, predicted;
    if (!rst_n) begin
      yel_used = '0;
      yel_count = 0;
      gate_q = GATE_RESET;
      answers_due.delete();
      errors = 0;
      checked = 0;
      paired = 0;
      full_hits = 0;
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding,", $time,
                   " got status=%0d mid=(%0d,%0d) slot=%0d",
                   out_res.status, $signed(out_res.mid_x), $signed(out_res.mid_y),
                   out_res.partner_slot);
        end else begin
          expected = answers_due.pop_front();
          checked++;
          if (expected.status == ST_PAIRED) paired++;
          if (expected.status == ST_FULL) full_hits++;
          if (out_res.status !== expected.status || out_res.mid_x !== expected.mid_x ||
              out_res.mid_y !== expected.mid_y ||
              out_res.partner_slot !== expected.partner_slot) begin
            errors++;
            $display("%0t: mismatch, expected status=%0d mid=(%0d,%0d) slot=%0d,",
                     $time, expected.status, $signed(expected.mid_x),
                     $signed(expected.mid_y), expected.partner_slot,
                     " got status=%0d mid=(%0d,%0d) slot=%0d",
                     out_res.status, $signed(out_res.mid_x),
                     $signed(out_res.mid_y), out_res.partner_slot);
          end
        end
      end
      if (cfg_we) gate_q = cfg_wdata;
      if (start && !busy) begin
        answer_for(in_req, predicted);
        answers_due = {answers_due, predicted};
      end
    end
    waiting = answers_due.size();
  end

endmodule

[sim/greedy_cone_pair_midpoints_unit_tb.sv]
// Testbench top for the greedy cone pairing block: request stimulus, gate settings and verdict.
`timescale 1ns / 1ps

module greedy_cone_pair_midpoints_unit_tb;
  import gcpm_pkg::*;

  localparam int     PHASE_ITEMS  = 200;
  localparam int     DRAIN_CYCLES = 80;
  localparam longint TIMEOUT_NS   = 20_000_000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_req_t           in_req;
  logic              out_valid;
  out_res_t          out_res;
  logic              cfg_we;
  logic [GATE_W-1:0] cfg_wdata;

  int errors, waiting, checked, paired, full_hits;
  int requests_sent = 0;
  int gate_settings = 0;
  int phase_base;
  logic [GATE_W-1:0] gate_now = GATE_RESET;
  bit quiet = 1'b0;

  always #4 clk = ~clk;

  greedy_cone_pair_midpoints_unit #(.MAX_CONES(MAX_CONES_DEF)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  gcpm_result_checker #(.TABLE_DEPTH(MAX_CONES_DEF)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .waiting   (waiting),
    .checked   (checked),
    .paired    (paired),
    .full_hits (full_hits)
  );

  function automatic longint clamp_coord(longint v);
    longint lim;
    lim = longint'(1) <<< (COORD_W - 1);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint rand_coord();
    logic signed [COORD_W-1:0] raw;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: return clamp_coord(longint'(1) <<< COORD_W);
        1: return clamp_coord(-(longint'(1) <<< COORD_W));
        2: return 0;
        default: return -1;
      endcase
    end
    raw = COORD_W'($urandom);
    return longint'(raw);
  endfunction

  function automatic longint near_offset(longint reach);
    return longint'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  function automatic in_req_t make_req(logic [REQ_W-1:0] kind, longint x, longint y);
    in_req_t r;
    r.req_type = kind;
    r.pos_x = COORD_W'(x);
    r.pos_y = COORD_W'(y);
    return r;
  endfunction

  task automatic send(input in_req_t r);
    int gap, pick;
    start <= 1'b1;
    in_req <= r;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    requests_sent++;
    gap = 0;
    if (!quiet) begin
      pick = $urandom_range(0, 99);
      if (pick >= 93) gap = $urandom_range(8, 40);
      else if (pick >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 8)
      send(make_req(REQ_W'($urandom_range(0, 3)), rand_coord(), rand_coord()));
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (waiting != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_gate(input logic [GATE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    gate_now = value;
    gate_settings++;
  endtask

  task automatic run_cone_set();
    longint ys_x [$];
    longint ys_y [$];
    longint bx, by, spread, reach, base_x, base_y;
    int     n_load, n_pair, k, pick;
    quiet = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) != 0) send(make_req(REQ_CLEAR, rand_coord(), rand_coord()));
    pick = $urandom_range(0, 99);
    if (pick < 85) n_load = $urandom_range(1, 12);
    else if (pick < 95) n_load = $urandom_range(13, 40);
    else n_load = $urandom_range(60, 70);
    spread = 4 * longint'(gate_now) + 256;
    if (spread > 32767) spread = 32767;
    base_x = rand_coord();
    base_y = rand_coord();
    for (int i = 0; i < n_load; i++) begin
      maybe_noise();
      if ($urandom_range(0, 9) == 0) begin
        bx = rand_coord();
        by = rand_coord();
      end else begin
        bx = clamp_coord(base_x + near_offset(spread));
        by = clamp_coord(base_y + near_offset(spread));
      end
      ys_x = {ys_x, bx};
      ys_y = {ys_y, by};
      send(make_req(REQ_LOAD, bx, by));
    end
    n_pair = $urandom_range(n_load / 2, n_load + 3);
    for (int i = 0; i < n_pair; i++) begin
      maybe_noise();
      k = $urandom_range(0, ys_x.size() - 1);
      pick = $urandom_range(0, 9);
      if (pick < 9) begin
        reach = (pick < 7) ? longint'(gate_now) * 3 / 4 : 2 * longint'(gate_now) + 1;
        bx = clamp_coord(ys_x[k] + near_offset(reach));
        by = clamp_coord(ys_y[k] + near_offset(reach));
      end else begin
        bx = rand_coord();
        by = rand_coord();
      end
      send(make_req(REQ_PAIR, bx, by));
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL greedy_cone_pair_midpoints_unit");
    $finish;
  end

  initial begin
    logic [GATE_W-1:0] gate_plan [6];
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part runs with the reset gate of 6.2 m.
    send(make_req(REQ_PAIR, 0, 0));
    send(make_req(REQ_LOAD, 0, 0));
    send(make_req(REQ_LOAD, 100, 0));
    send(make_req(REQ_PAIR, 50, 0));
    send(make_req(REQ_PAIR, 50, 0));
    send(make_req(REQ_PAIR, 50, 0));
    send(make_req(REQ_LOAD, 2000, 0));
    send(make_req(REQ_PAIR, 0, 0));
    send(make_req(REQ_PAIR, 413, 0));
    send(make_req(REQ_RSVD, -1, -1));
    send(make_req(REQ_CLEAR, 0, 0));
    send(make_req(REQ_LOAD, 32767, 32767));
    send(make_req(REQ_LOAD, -32768, -32768));
    send(make_req(REQ_LOAD, -3, 5));
    send(make_req(REQ_PAIR, 32767, 32767));
    send(make_req(REQ_PAIR, -32768, -32767));
    send(make_req(REQ_PAIR, 0, 0));
    send(make_req(REQ_LOAD, -32768, 32767));
    send(make_req(REQ_PAIR, 32767, -32768));
    send(make_req(REQ_CLEAR, -1, -1));

    gate_plan[0] = '0;
    gate_plan[1] = GATE_W'(32767);
    gate_plan[2] = GATE_W'($urandom_range(1, 4000));
    gate_plan[3] = GATE_W'(1);
    gate_plan[4] = GATE_RESET;
    gate_plan[5] = GATE_W'($urandom_range(0, 32767));
    for (int p = 0; p < 6; p++) begin
      settle();
      write_gate(gate_plan[p]);
      phase_base = requests_sent;
      while (requests_sent - phase_base < PHASE_ITEMS) run_cone_set();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests under %0d written gate settings plus the reset gate.",
             requests_sent, gate_settings);
    $display("Checked %0d results: %0d pairings and %0d table-full answers.",
             checked, paired, full_hits);
    if (errors == 0 && waiting == 0) begin
      $display("PASS greedy_cone_pair_midpoints_unit");
    end else begin
      $display("FAIL greedy_cone_pair_midpoints_unit");
    end
    $finish;
  end

endmodule
